// ===== src/cfrds_pkg.sv =====
`timescale 1ns / 1ps

package cfrds_pkg;

	// Field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned POS_W   = 3;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [POS_W-1:0]   pos_t;

	// Frame layout
	localparam byte_t SYNC_BYTE    = 8'hAA;
	localparam pos_t  POS_HUNT     = 3'd0;
	localparam pos_t  POS_MODE     = 3'd1;
	localparam pos_t  POS_EMG      = 3'd4;
	localparam pos_t  POS_CONTACT  = 3'd5;
	localparam pos_t  POS_CHECKSUM = 3'd6;

	// Command codes
	localparam byte_t OFF_MODE = 8'h00;
	localparam byte_t RUN_MODE = 8'h01;
	localparam byte_t EMG_MODE = 8'h02;
	localparam byte_t EMG_FWD  = 8'h01;
	localparam byte_t EMG_REV  = 8'h02;

	localparam level_t DRIVE_RESET = 10'd400;

	typedef enum logic [1:0] {
		DRIVE_STOP = 2'd0,
		DRIVE_FWD  = 2'd1,
		DRIVE_REV  = 2'd2
	} drive_t;

endpackage

// ===== src/command_frame_receiver_drive_select.sv =====
`timescale 1ns / 1ps

// Channel | Handshake           | Payload
// --------+---------------------+-------------------------------------------------
// in      | in_valid/in_ready   | byte_valid, rx_byte, forward_pressed,
//         |                     | reverse_pressed
// out     | out_valid/out_ready | pwm_level, direction, frame_accepted,
//         |                     | frame_rejected
// cfg     | cfg_valid/cfg_ready | cfg_data (drive level)
//
// One input transaction per cycle while in_ready is high; its result sits in the
// output register in the cycle after acceptance. Frame parsing and the drive
// decision are one pass of logic between the input handshake and that register.
// Input is accepted whenever the output register is empty or being drained, so
// a stall on the output side holds the input side only while a result waits.
// Reset clears the parser, the latched command (run mode) and the level (400).

module command_frame_receiver_drive_select (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  byte_valid,
	input  cfrds_pkg::byte_t      rx_byte,
	input  logic                  forward_pressed,
	input  logic                  reverse_pressed,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cfrds_pkg::level_t     pwm_level,
	output logic                  direction,
	output logic                  frame_accepted,
	output logic                  frame_rejected,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfrds_pkg::level_t     cfg_data
);
	import cfrds_pkg::*;

	logic   in_fire;
	level_t drive_level_q;

	pos_t  pos_q, pos_d;
	byte_t xor_q, xor_d;
	byte_t pend_mode_q, pend_emg_q, pend_contact_q;
	byte_t act_mode_q, act_emg_q, act_contact_q;
	byte_t act_mode_d, act_emg_d, act_contact_d;
	logic  last_dir_q, last_dir_d;
	logic  acc_d, rej_d;
	drive_t drive;

	logic   out_valid_s1;
	level_t pwm_level_s1;
	logic   direction_s1;
	logic   frame_accepted_s1;
	logic   frame_rejected_s1;

	assign in_ready  = !out_valid_s1 || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Hold the drive level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_level_q <= DRIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			drive_level_q <= cfg_data;
		end
	end

	// Advance the frame parser for this transaction
	always_comb begin
		pos_d         = pos_q;
		xor_d         = xor_q;
		act_mode_d    = act_mode_q;
		act_emg_d     = act_emg_q;
		act_contact_d = act_contact_q;
		acc_d         = 1'b0;
		rej_d         = 1'b0;
		if (byte_valid) begin
			if (pos_q == POS_HUNT) begin
				if (rx_byte == SYNC_BYTE) begin
					xor_d = '0;
					pos_d = POS_MODE;
				end
			end else if (pos_q >= POS_CHECKSUM) begin
				pos_d = POS_HUNT;
				if (xor_q == rx_byte) begin
					act_mode_d    = pend_mode_q;
					act_emg_d     = pend_emg_q;
					act_contact_d = pend_contact_q;
					acc_d         = 1'b1;
				end else begin
					rej_d = 1'b1;
				end
			end else begin
				xor_d = xor_q ^ rx_byte;
				pos_d = pos_q + 3'd1;
			end
		end
	end

	// Select the drive command from the latched command and the switches
	always_comb begin
		drive = DRIVE_STOP;
		if (act_mode_d == OFF_MODE || act_contact_d != '0) begin
			drive = DRIVE_STOP;
		end else if (act_mode_d == EMG_MODE) begin
			if (act_emg_d == EMG_FWD) begin
				drive = DRIVE_FWD;
			end else if (act_emg_d == EMG_REV) begin
				drive = DRIVE_REV;
			end
		end else if (forward_pressed && !reverse_pressed) begin
			drive = DRIVE_FWD;
		end else if (reverse_pressed && !forward_pressed) begin
			drive = DRIVE_REV;
		end
	end

	always_comb begin
		last_dir_d = last_dir_q;
		if (drive == DRIVE_FWD) begin
			last_dir_d = 1'b1;
		end else if (drive == DRIVE_REV) begin
			last_dir_d = 1'b0;
		end
	end

	// Update parser and command state on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= POS_HUNT;
			xor_q         <= '0;
			act_mode_q    <= RUN_MODE;
			act_emg_q     <= '0;
			act_contact_q <= '0;
			last_dir_q    <= 1'b0;
		end else if (in_fire) begin
			pos_q         <= pos_d;
			xor_q         <= xor_d;
			act_mode_q    <= act_mode_d;
			act_emg_q     <= act_emg_d;
			act_contact_q <= act_contact_d;
			last_dir_q    <= last_dir_d;
		end
	end

	// Capture frame fields as they pass
	always_ff @(posedge clk) begin
		if (in_fire && byte_valid) begin
			if (pos_q == POS_MODE) begin
				pend_mode_q <= rx_byte;
			end
			if (pos_q == POS_EMG) begin
				pend_emg_q <= rx_byte;
			end
			if (pos_q == POS_CONTACT) begin
				pend_contact_q <= rx_byte;
			end
		end
	end

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			out_valid_s1 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pwm_level_s1      <= (drive != DRIVE_STOP) ? drive_level_q : '0;
			direction_s1      <= last_dir_d;
			frame_accepted_s1 <= acc_d;
			frame_rejected_s1 <= rej_d;
		end
	end

	assign out_valid      = out_valid_s1;
	assign pwm_level      = pwm_level_s1;
	assign direction      = direction_s1;
	assign frame_accepted = frame_accepted_s1;
	assign frame_rejected = frame_rejected_s1;

	// A frame verdict is never both good and bad
	a_verdict_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 |-> !(frame_accepted_s1 && frame_rejected_s1))
		else $error("frame accepted and rejected together");

	// A verdict leaves the parser hunting for the next start byte
	a_verdict_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (acc_d || rej_d) |=> pos_q == POS_HUNT)
		else $error("parser not back to hunting after a frame");

	// A stray byte while hunting is dropped
	a_hunt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && byte_valid && pos_q == POS_HUNT && rx_byte != SYNC_BYTE
		|=> pos_q == POS_HUNT)
		else $error("parser left hunting without a start byte");

	// A transaction without a byte leaves the parser alone
	a_no_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !byte_valid |=> $stable(pos_q) && $stable(xor_q))
		else $error("parser moved without a byte");

	// The position never reaches the unused code
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 3'd7)
		else $error("byte position out of range");

endmodule
